>>> hdl/rrvp_pkg.sv
`default_nettype none

package rrvp_pkg;

	// Configuration register map (register index = paddr[2]).
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned RIDX_W  = 1;
	localparam logic [RIDX_W-1:0] REG_STOP_LOSS   = 1'b0;
	localparam logic [RIDX_W-1:0] REG_TAKE_PROFIT = 1'b1;

	// Arithmetic constants.
	localparam logic [6:0]  LEV_SCALE = 7'd100;
	localparam logic [16:0] ONE_Q16   = 17'h10000;

	// Serial divider: one quotient bit per cycle.
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned DIV_CNT_W = 5;

	typedef struct packed {
		logic capture;
		logic cnt_clr;
		logic fill;
		logic scan;
		logic prep;
		logic chk;
		logic div_step;
		logic mul_stop;
		logic mul_tgt;
		logic out_load;
	} rrvp_cmd_t;

	typedef struct packed {
		logic primed;
		logic fill_last;
		logic scan_last;
		logic out_free;
	} rrvp_sts_t;

endpackage

`default_nettype wire

>>> hdl/rrvp_tick_if.sv
`default_nettype none

interface rrvp_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] low_price;
	logic [31:0] high_price;
	logic        period_event;
	logic        position_short;

	modport source (
		output valid, low_price, high_price, period_event, position_short,
		input  ready
	);
	modport sink (
		input  valid, low_price, high_price, period_event, position_short,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/rrvp_res_if.sv
`default_nettype none

interface rrvp_res_if;
	logic        valid;
	logic        ready;
	logic        event_out;
	logic [31:0] leverage;
	logic [31:0] stop_price;
	logic [31:0] target_price;

	modport source (
		output valid, event_out, leverage, stop_price, target_price,
		input  ready
	);
	modport sink (
		input  valid, event_out, leverage, stop_price, target_price,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/rrvp_ram.sv
`default_nettype none

module rrvp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/rrvp_ctrl.sv
`default_nettype none

module rrvp_ctrl
	import rrvp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      tick_valid,
	output logic           tick_ready,
	input  wire rrvp_sts_t sts,
	output rrvp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_PREP,
		ST_CHK,
		ST_DIV,
		ST_MSTOP,
		ST_MTGT,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_valid) begin
						state_q <= sts.primed ? ST_SCAN : ST_FILL;
					end
				end
				ST_FILL: begin
					if (sts.fill_last) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					div_cnt_q <= '0;
					state_q   <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_MSTOP;
					end
				end
				ST_MSTOP: begin
					state_q <= ST_MTGT;
				end
				ST_MTGT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign tick_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.cnt_clr = 1'b1;
				cmd.capture = tick_valid;
			end
			ST_FILL: begin
				cmd.fill    = 1'b1;
				cmd.cnt_clr = sts.fill_last;
			end
			ST_SCAN:  cmd.scan     = 1'b1;
			ST_PREP:  cmd.prep     = 1'b1;
			ST_CHK:   cmd.chk      = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_MSTOP: cmd.mul_stop = 1'b1;
			ST_MTGT:  cmd.mul_tgt  = 1'b1;
			ST_OUT:   cmd.out_load = sts.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/rrvp_dp.sv
`default_nettype none

module rrvp_dp
	import rrvp_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rrvp_cmd_t   cmd,
	output rrvp_sts_t        sts,
	input  wire logic [31:0] low_price,
	input  wire logic [31:0] high_price,
	input  wire logic        period_event,
	input  wire logic        position_short,
	input  wire logic [15:0] stop_loss_fraction,
	input  wire logic [15:0] take_profit_fraction,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic             event_out,
	output logic [31:0]      leverage,
	output logic [31:0]      stop_price,
	output logic [31:0]      target_price
);

	localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

	// Captured item.
	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic        ev_q;
	logic        sh_q;
	logic [32:0] sum_q;

	// Window control.
	logic [AW-1:0] slot_q;
	logic          primed_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] raddr_q;

	// Scan results and leverage math.
	logic [31:0] mn_q;
	logic [31:0] mx_q;
	logic [38:0] d100_q;
	logic        zero_q;
	logic        neg_q;
	logic        ovf_q;
	logic [31:0] rem_q;
	logic [31:0] numlo_q;
	logic [31:0] quo_q;
	logic [31:0] stop_q;
	logic [31:0] tgt_q;

	// Result register.
	logic        out_valid_q;
	logic        out_ev_q;
	logic [31:0] out_lev_q;
	logic [31:0] out_stop_q;
	logic [31:0] out_tgt_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   low_rd;
	logic [31:0]   high_rd;
	logic          scan_take;
	logic [32:0]   rem_shift;
	logic          rem_ge;
	logic [32:0]   rem_sub;
	logic [16:0]   factor;
	logic [49:0]   prod;
	logic [31:0]   prod_sat;
	logic [31:0]   lev_final;

	assign ram_we    = cmd.fill || (cmd.scan && (cnt_q == '0));
	assign ram_waddr = cmd.fill ? cnt_q[AW-1:0] : slot_q;

	rrvp_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_low_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (lo_q),
		.raddr (cnt_q[AW-1:0]),
		.rdata (low_rd)
	);

	rrvp_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_high_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (hi_q),
		.raddr (cnt_q[AW-1:0]),
		.rdata (high_rd)
	);

	// The current slot is already folded in from the captured item, so its
	// stored copy is skipped during the scan.
	assign scan_take = cmd.scan && (cnt_q != '0) && (raddr_q != slot_q);

	assign rem_shift = {rem_q, numlo_q[31]};
	assign rem_ge    = (rem_shift >= {1'b0, mn_q});
	assign rem_sub   = rem_shift - {1'b0, mn_q};

	always_comb begin
		if (cmd.mul_stop) begin
			factor = sh_q ? (ONE_Q16 + {1'b0, stop_loss_fraction})
			              : (ONE_Q16 - {1'b0, stop_loss_fraction});
		end else begin
			factor = sh_q ? (ONE_Q16 - {1'b0, take_profit_fraction})
			              : (ONE_Q16 + {1'b0, take_profit_fraction});
		end
	end

	assign prod     = 50'(sum_q) * 50'(factor);
	assign prod_sat = prod[49] ? 32'hFFFF_FFFF : prod[48:17];

	always_comb begin
		if (zero_q || (!neg_q && ovf_q)) begin
			lev_final = 32'hFFFF_FFFF;
		end else if (neg_q) begin
			lev_final = '0;
		end else begin
			lev_final = quo_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			primed_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.fill || cmd.scan) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.fill) begin
				primed_q <= 1'b1;
			end
			if (cmd.out_load && ev_q) begin
				slot_q <= (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		raddr_q <= cnt_q[AW-1:0];
		if (cmd.capture) begin
			lo_q  <= low_price;
			hi_q  <= high_price;
			ev_q  <= period_event;
			sh_q  <= position_short;
			sum_q <= {1'b0, low_price} + {1'b0, high_price};
			mn_q  <= low_price;
			mx_q  <= high_price;
		end
		if (scan_take) begin
			if (low_rd < mn_q) begin
				mn_q <= low_rd;
			end
			if (high_rd > mx_q) begin
				mx_q <= high_rd;
			end
		end
		if (cmd.prep) begin
			d100_q <= 39'(mx_q - mn_q) * 39'(LEV_SCALE);
			zero_q <= (mn_q == '0);
			neg_q  <= (mx_q < mn_q);
		end
		if (cmd.chk) begin
			rem_q   <= {9'b0, d100_q[38:16]};
			numlo_q <= {d100_q[15:0], 16'b0};
			ovf_q   <= ({9'b0, d100_q[38:16]} >= mn_q);
		end
		if (cmd.div_step) begin
			rem_q   <= rem_ge ? rem_sub[31:0] : rem_shift[31:0];
			numlo_q <= {numlo_q[30:0], 1'b0};
			quo_q   <= {quo_q[30:0], rem_ge};
		end
		if (cmd.mul_stop) begin
			stop_q <= ev_q ? prod_sat : '0;
		end
		if (cmd.mul_tgt) begin
			tgt_q <= ev_q ? prod_sat : '0;
		end
		if (cmd.out_load) begin
			out_ev_q   <= ev_q;
			out_lev_q  <= lev_final;
			out_stop_q <= stop_q;
			out_tgt_q  <= tgt_q;
		end
	end

	assign sts.primed    = primed_q;
	assign sts.fill_last = (cnt_q == CW'(WINDOW_DEPTH - 1));
	assign sts.scan_last = (cnt_q == CW'(WINDOW_DEPTH));
	assign sts.out_free  = !out_valid_q || res_ready;

	assign res_valid    = out_valid_q;
	assign event_out    = out_ev_q;
	assign leverage     = out_lev_q;
	assign stop_price   = out_stop_q;
	assign target_price = out_tgt_q;

endmodule

`default_nettype wire

>>> hdl/rolling_range_volatility_policy_unit.sv
// Channel   Dir   Handshake      Payload per beat
// tick      in    valid/ready    low_price, high_price, period_event, position_short
// res       out   valid/ready    event_out, leverage, stop_price, target_price
// apb       in    psel/penable   paddr, pwdata, pwrite (pready tied high), prdata out
//
// After acceptance a tick passes through the window scan, the leverage
// division and the stop and target scaling before its result is loaded; the
// very first tick after reset first fills every slot of both windows.
// A tick's processing time is set by the window scan, one RAM read per slot,
// and by the restoring divider that forms the leverage quotient.
// Reset is asynchronous and active low; window contents are not cleared.
// The next tick is accepted while an earlier result still waits in the output
// register; a stalled result only holds the controller in its final state.
`default_nettype none

module rolling_range_volatility_policy_unit
	import rrvp_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rrvp_tick_if.sink              tick,
	rrvp_res_if.source             res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	// Configuration registers, both Q0.16 fractions of the mid price.
	logic [15:0] stop_loss_q;
	logic [15:0] take_profit_q;

	logic [RIDX_W-1:0] reg_idx;
	logic              cfg_write;

	rrvp_cmd_t cmd;
	rrvp_sts_t sts;

	// The register index is taken from the word address; the byte offset
	// within a word is ignored.
	assign reg_idx   = paddr[APB_AW-1:2];
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_loss_q   <= '0;
			take_profit_q <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_STOP_LOSS:   stop_loss_q   <= pwdata[15:0];
				REG_TAKE_PROFIT: take_profit_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STOP_LOSS:   prdata = {16'b0, stop_loss_q};
			REG_TAKE_PROFIT: prdata = {16'b0, take_profit_q};
			default:         prdata = '0;
		endcase
	end

	// The controller sequences fill, scan, divide and scaling steps; the
	// datapath holds the windows, the arithmetic and the result register.
	rrvp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	rrvp_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.low_price            (tick.low_price),
		.high_price           (tick.high_price),
		.period_event         (tick.period_event),
		.position_short       (tick.position_short),
		.stop_loss_fraction   (stop_loss_q),
		.take_profit_fraction (take_profit_q),
		.res_valid            (res.valid),
		.res_ready            (res.ready),
		.event_out            (res.event_out),
		.leverage             (res.leverage),
		.stop_price           (res.stop_price),
		.target_price         (res.target_price)
	);

endmodule

`default_nettype wire
